/* rtl/s2b_pkg.sv */
// Shared constants, types and helpers for the scan-to-bitmap rasterizer.
`timescale 1ns / 1ps
package s2b_pkg;

	// image and scan geometry
	localparam int IMG_DIM    = 512;
	localparam int MAX_BEAMS  = 4096;
	localparam int WPR        = (IMG_DIM + 63) / 64;
	localparam int MAP_WORDS  = IMG_DIM * WPR;
	localparam int AW         = $clog2(MAP_WORDS);
	localparam int CW         = $clog2(IMG_DIM);
	localparam int HALF       = IMG_DIM / 2;

	// divider: quotient bits and numerator width (r * mag * IMG_DIM)
	localparam int QW       = $clog2(IMG_DIM);
	localparam int NW       = 34 + $clog2(IMG_DIM + 1);
	localparam int GEOM_LAT = 9 + QW;

	// quarter-wave sine polynomial
	localparam int POLY_A = 102944;
	localparam int POLY_B = 42048;
	localparam int POLY_C = 4640;
	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd3;

	// item actions
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	typedef enum logic {
		BM_CLEAR,
		BM_RUN
	} bm_state_t;

	// fields carried alongside the math pipeline
	typedef struct packed {
		logic        action;
		logic        scan_start;
		logic [8:0]  read_row;
		logic [2:0]  read_word;
		logic [15:0] range_q;
		logic        ok;
		logic        neg_x;
		logic        neg_y;
	} side_t;

	// item handed from the geometry pipeline to the bitmap stage
	typedef struct packed {
		logic          action;
		logic          scan_start;
		logic          set;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [8:0]    read_row;
		logic [2:0]    read_word;
	} pix_item_t;

	// quadrant fold: {negative, t} with t in Q16 [0, 65536]
	function automatic logic [17:0] fold_phase(input logic [15:0] p);
		logic [14:0] f;
		f = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
		return {p[15], f, 2'b00};
	endfunction

endpackage

/* rtl/s2b_in_if.sv */
// Input channel interface: range samples and read requests.
`timescale 1ns / 1ps
interface s2b_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] range_q;
	logic [11:0] beam_index;
	logic        scan_start;
	logic [8:0]  read_row;
	logic [2:0]  read_word;

	modport source (output valid, action, range_q, beam_index, scan_start, read_row,
		read_word, input ready);
	modport sink (input valid, action, range_q, beam_index, scan_start, read_row,
		read_word, output ready);
endinterface

/* rtl/s2b_out_if.sv */
// Output channel interface: pixel results and bitmap words.
`timescale 1ns / 1ps
interface s2b_out_if;
	logic        valid;
	logic        ready;
	logic [8:0]  pixel_x;
	logic [8:0]  pixel_y;
	logic        pixel_set;
	logic [63:0] image_word;

	modport source (output valid, pixel_x, pixel_y, pixel_set, image_word, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_set, image_word, output ready);
endinterface

/* rtl/s2b_geom.sv */
// Config registers and the pipelined angle, sine polynomial and divider datapath.
`timescale 1ns / 1ps
module s2b_geom (
	input  logic                           clk,
	input  logic                           arst_n,
	s2b_in_if.sink                         in_ch,
	input  logic                           cfg_we,
	input  logic [s2b_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data,
	output logic                           out_valid,
	output s2b_pkg::pix_item_t             out_item,
	input  logic                           out_ready
);
	import s2b_pkg::*;

	logic [15:0] range_low_q, range_high_q, start_angle_q, angle_step_q;

	logic        v_s [1:GEOM_LAT];
	side_t       side_s [1:GEOM_LAT];
	logic        en;

	logic [15:0] phase_s1;
	logic [16:0] t_s2 [2];
	logic [16:0] t_s3 [2];
	logic [16:0] t2_s3 [2];
	logic [16:0] t_s4 [2];
	logic [16:0] t2_s4 [2];
	logic [15:0] inner_s4 [2];
	logic [16:0] t_s5 [2];
	logic [16:0] mid_s5 [2];
	logic [17:0] mag_s6 [2];
	logic [33:0] p_s7 [2];
	logic [NW-1:0] n_s8 [2];
	logic [NW-1:0] div_rem_s [QW][2];
	logic [QW-1:0] div_q_s [QW][2];
	logic [NW-1:0] div_rem_n [QW][2];
	logic [QW-1:0] div_q_n [QW][2];
	logic [CW-1:0] x_sf, y_sf;
	logic          set_sf;

	logic [15:0] phase_c;
	logic        ok_c;
	side_t       side_c1, side_c2;
	logic [17:0] fold_c [2];
	logic [16:0] t2_c [2];
	logic [15:0] inner_c [2];
	logic [16:0] mid_c [2];
	logic [17:0] mag_c [2];
	logic [29:0] ct_c [2];
	logic [32:0] ti_c [2];
	logic [33:0] tm_c [2];
	logic [NW-1:0] dsh_c;
	logic [CW-1:0] coord_c [2];
	logic          inimg_c [2];
	logic [31:0]   step_prod_c;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q   <= 16'd0;
			range_high_q  <= 16'hFFFF;
			start_angle_q <= 16'd0;
			angle_step_q  <= 16'd182;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_LOW:   range_low_q   <= cfg_data;
				REG_RANGE_HIGH:  range_high_q  <= cfg_data;
				REG_START_ANGLE: start_angle_q <= cfg_data;
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the last stage is blocked
	assign en          = !v_s[GEOM_LAT] || out_ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= GEOM_LAT; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_ch.valid;
			for (int k = 2; k <= GEOM_LAT; k++) v_s[k] <= v_s[k-1];
		end
	end

	// beam angle and range gate
	always_comb begin
		step_prod_c = 32'(in_ch.beam_index) * 32'(angle_step_q);
		phase_c = 16'(start_angle_q + step_prod_c[15:0]);
		ok_c = (in_ch.action == ACT_SAMPLE) && (32'(in_ch.beam_index) < MAX_BEAMS) &&
			(in_ch.range_q > range_low_q) && (in_ch.range_q < range_high_q);
		side_c1.action     = in_ch.action;
		side_c1.scan_start = in_ch.scan_start;
		side_c1.read_row   = in_ch.read_row;
		side_c1.read_word  = in_ch.read_word;
		side_c1.range_q    = in_ch.range_q;
		side_c1.ok         = ok_c;
		side_c1.neg_x      = 1'b0;
		side_c1.neg_y      = 1'b0;
	end

	// polynomial terms per lane (lane 0 is cosine/x, lane 1 is sine/y)
	always_comb begin
		fold_c[0] = fold_phase(16'(phase_s1 + QUARTER_TURN));
		fold_c[1] = fold_phase(phase_s1);
		side_c2       = side_s[1];
		side_c2.neg_x = fold_c[0][17];
		side_c2.neg_y = fold_c[1][17];
		for (int l = 0; l < 2; l++) begin
			t2_c[l]    = 17'((34'(t_s2[l]) * 34'(t_s2[l])) >> 16);
			ct_c[l]    = 30'(POLY_C) * 30'(t2_s3[l]);
			inner_c[l] = 16'(32'(POLY_B) - 32'(ct_c[l] >> 16));
			ti_c[l]    = 33'(t2_s4[l]) * 33'(inner_s4[l]);
			mid_c[l]   = 17'(32'(POLY_A) - 32'(ti_c[l] >> 16));
			tm_c[l]    = 34'(t_s5[l]) * 34'(mid_s5[l]);
			mag_c[l]   = 18'(tm_c[l] >> 16);
		end
	end

	// restoring divider, one quotient bit per stage
	always_comb begin
		dsh_c = NW'({range_high_q, 17'd0});
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < 2; l++) begin
				div_rem_n[k][l] = (k == 0) ? n_s8[l] : div_rem_s[k-1][l];
				div_q_n[k][l]   = (k == 0) ? '0 : div_q_s[k-1][l];
				if (div_rem_n[k][l] >= (dsh_c << (QW - 1 - k))) begin
					div_rem_n[k][l] = div_rem_n[k][l] - (dsh_c << (QW - 1 - k));
					div_q_n[k][l][QW-1-k] = 1'b1;
				end
			end
		end
	end

	// signed offset around the image center and bounds check
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if ((l == 0) ? side_s[GEOM_LAT-1].neg_x : side_s[GEOM_LAT-1].neg_y) begin
				inimg_c[l] = 32'(div_q_s[QW-1][l]) <= HALF;
				coord_c[l] = CW'(32'(HALF) - 32'(div_q_s[QW-1][l]));
			end else begin
				inimg_c[l] = 32'(div_q_s[QW-1][l]) < (IMG_DIM - HALF);
				coord_c[l] = CW'(32'(HALF) + 32'(div_q_s[QW-1][l]));
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= side_c1;
			phase_s1  <= phase_c;
			side_s[2] <= side_c2;
			for (int k = 3; k <= GEOM_LAT; k++) side_s[k] <= side_s[k-1];

			for (int l = 0; l < 2; l++) begin
				t_s2[l]     <= fold_c[l][16:0];
				t_s3[l]     <= t_s2[l];
				t2_s3[l]    <= t2_c[l];
				t_s4[l]     <= t_s3[l];
				t2_s4[l]    <= t2_s3[l];
				inner_s4[l] <= inner_c[l];
				t_s5[l]     <= t_s4[l];
				mid_s5[l]   <= mid_c[l];
				mag_s6[l]   <= mag_c[l];
				p_s7[l]     <= 34'(side_s[6].range_q) * 34'(mag_s6[l]);
				n_s8[l]     <= NW'(p_s7[l]) * NW'(IMG_DIM);
				for (int k = 0; k < QW; k++) begin
					div_rem_s[k][l] <= div_rem_n[k][l];
					div_q_s[k][l]   <= div_q_n[k][l];
				end
			end

			set_sf <= side_s[GEOM_LAT-1].ok && inimg_c[0] && inimg_c[1];
			x_sf   <= (side_s[GEOM_LAT-1].ok && inimg_c[0] && inimg_c[1]) ? coord_c[0] : '0;
			y_sf   <= (side_s[GEOM_LAT-1].ok && inimg_c[0] && inimg_c[1]) ? coord_c[1] : '0;
		end
	end

	assign out_valid           = v_s[GEOM_LAT];
	assign out_item.action     = side_s[GEOM_LAT].action;
	assign out_item.scan_start = side_s[GEOM_LAT].scan_start;
	assign out_item.set        = set_sf;
	assign out_item.x          = x_sf;
	assign out_item.y          = y_sf;
	assign out_item.read_row   = side_s[GEOM_LAT].read_row;
	assign out_item.read_word  = side_s[GEOM_LAT].read_word;

endmodule

/* rtl/s2b_bitmap.sv */
// Bitmap memory with read-modify-write, forwarding, clear sweep and output register.
`timescale 1ns / 1ps
module s2b_bitmap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  s2b_pkg::pix_item_t in_item,
	output logic               in_ready,
	s2b_out_if.source          out_ch
);
	import s2b_pkg::*;

	logic [63:0]   mem [MAP_WORDS];
	logic [63:0]   rd_data_q;

	bm_state_t     state_q, state_n;
	logic [AW-1:0] clr_cnt_q;
	logic          clean_q;
	logic          sweep, sweep_last;

	logic          v_s1;
	pix_item_t     item_s1;
	logic [AW-1:0] addr_s1;
	logic          inimg_s1;
	logic          fwd_hit_s1;
	logic [63:0]   fwd_data_s1;

	logic          out_valid_q;
	logic [8:0]    pixel_x_q, pixel_y_q;
	logic          pixel_set_q;
	logic [63:0]   image_word_q;

	logic          accept, need_clear, out_free, s1_move;
	logic [AW-1:0] raddr, waddr;
	logic          we;
	logic [63:0]   wdata, merged;

	// handshake and hazards
	always_comb begin
		out_free   = !out_valid_q || out_ch.ready;
		s1_move    = v_s1 && out_free;
		need_clear = (in_item.action == ACT_SAMPLE) && in_item.scan_start && !clean_q;
		in_ready   = (state_q == BM_RUN) && !need_clear && (!v_s1 || out_free);
		accept     = in_valid && in_ready;
		sweep_last = 32'(clr_cnt_q) == (MAP_WORDS - 1);
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BM_CLEAR: if (sweep_last) state_n = BM_RUN;
			BM_RUN:   if (in_valid && need_clear && !v_s1) state_n = BM_CLEAR;
			default:  state_n = BM_RUN;
		endcase
	end

	// state outputs
	always_comb begin
		unique case (state_q)
			BM_CLEAR: sweep = 1'b1;
			BM_RUN:   sweep = 1'b0;
			default:  sweep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BM_CLEAR;
			clr_cnt_q <= '0;
			clean_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (sweep) clr_cnt_q <= sweep_last ? '0 : clr_cnt_q + 1'b1;
			if (sweep && sweep_last) clean_q <= 1'b1;
			else if (accept && in_item.action == ACT_SAMPLE) clean_q <= 1'b0;
		end
	end

	// address of the incoming item and the write from stage one
	always_comb begin
		if (in_item.action == ACT_READ)
			raddr = AW'(32'(in_item.read_row) * WPR + 32'(in_item.read_word));
		else
			raddr = AW'(32'(in_item.y) * WPR + 32'(in_item.x >> 6));
		merged = fwd_hit_s1 ? fwd_data_s1 : rd_data_q;
		we     = sweep || (s1_move && item_s1.action == ACT_SAMPLE && item_s1.set);
		waddr  = sweep ? clr_cnt_q : addr_s1;
		wdata  = sweep ? 64'd0 : (merged | (64'd1 << item_s1.x[5:0]));
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (accept) rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// stage one: holds the item while its read data arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (accept) v_s1 <= 1'b1;
		else if (s1_move) v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= in_item;
			addr_s1     <= raddr;
			inimg_s1    <= (32'(in_item.read_row) < IMG_DIM) &&
				(32'(in_item.read_word) < WPR);
			fwd_hit_s1  <= we && (waddr == raddr);
			fwd_data_s1 <= wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (s1_move) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			if (item_s1.action == ACT_READ) begin
				pixel_x_q    <= 9'd0;
				pixel_y_q    <= 9'd0;
				pixel_set_q  <= 1'b0;
				image_word_q <= inimg_s1 ? merged : 64'd0;
			end else begin
				pixel_x_q    <= 9'(item_s1.x);
				pixel_y_q    <= 9'(item_s1.y);
				pixel_set_q  <= item_s1.set;
				image_word_q <= 64'd0;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.pixel_x    = pixel_x_q;
	assign out_ch.pixel_y    = pixel_y_q;
	assign out_ch.pixel_set  = pixel_set_q;
	assign out_ch.image_word = image_word_q;

endmodule

/* rtl/scan_to_bitmap_rasterizer.sv */
// Top level of the scan-to-bitmap rasterizer.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  in_ch    | sink      | action, range_q, beam_index, scan_start, row/word
//  out_ch   | source    | pixel_x, pixel_y, pixel_set, image_word
//  cfg      | write     | cfg_we, cfg_index, cfg_data (16 bits)
//
// One item per cycle while no output stall or clear sweep holds the flow; the
// geometry pipeline has 9 + log2(IMG_DIM) stages (sine polynomial, multiplies,
// one divider stage per quotient bit), then the bitmap read stage and output register.
// After reset the bitmap is swept to zero, one word per cycle;
// in_ch.ready drops once the geometry pipeline has filled behind the sweep.
// A sample with scan_start waits at the bitmap input for the item in the read
// stage to leave, then triggers the same sweep unless the bitmap is still clear.
// An output stall holds the pipeline only once its last stage is occupied.
`timescale 1ns / 1ps
module scan_to_bitmap_rasterizer (
	input  logic                          clk,
	input  logic                          arst_n,
	s2b_in_if.sink                        in_ch,
	s2b_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [s2b_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import s2b_pkg::*;

	logic      geo_valid, geo_ready;
	pix_item_t geo_item;

	s2b_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (geo_valid),
		.out_item  (geo_item),
		.out_ready (geo_ready)
	);

	s2b_bitmap u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (geo_valid),
		.in_item  (geo_item),
		.in_ready (geo_ready),
		.out_ch   (out_ch)
	);

endmodule

/* rtl/s2b_checker.sv */
// Port-level assertions for the rasterizer and their bind.
`timescale 1ns / 1ps
module s2b_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [8:0]  pixel_x,
	input logic [8:0]  pixel_y,
	input logic        pixel_set,
	input logic [63:0] image_word
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a sample that set a pixel never carries a bitmap word
	a_set_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_set |-> image_word == 64'd0)
		else $error("pixel result with nonzero image word");

	// no pixel means zero coordinates
	a_unset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_set |-> pixel_x == 9'd0 && pixel_y == 9'd0)
		else $error("coordinates without a set pixel");

endmodule

bind scan_to_bitmap_rasterizer s2b_checker u_s2b_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.pixel_x    (out_ch.pixel_x),
	.pixel_y    (out_ch.pixel_y),
	.pixel_set  (out_ch.pixel_set),
	.image_word (out_ch.image_word)
);

/* sim/scan_to_bitmap_rasterizer_tb.sv */
// Self-checking testbench for the scan-to-bitmap rasterizer.
`timescale 1ns / 1ps
module scan_to_bitmap_rasterizer_tb;
	import s2b_pkg::*;

	typedef struct {
		logic        action;
		logic [15:0] range_q;
		logic [11:0] beam;
		logic        scan_start;
		logic [8:0]  row;
		logic [2:0]  word;
	} scan_item_t;

	typedef struct {
		logic [8:0]  px;
		logic [8:0]  py;
		logic        set;
		logic [63:0] img;
	} pix_result_t;

	// Raster predictor plus queue of expected results
	class raster_board;
		logic [63:0]  bmap [MAP_WORDS];
		logic [15:0]  r_low, r_high, a_start, a_step;
		pix_result_t  awaited[$];
		int           errors, samples, pixels, reads, clears;
		logic [8:0]   hit_x, hit_y;

		function new();
			foreach (bmap[i]) bmap[i] = '0;
			r_low = 16'd0; r_high = 16'd65535; a_start = 16'd0; a_step = 16'd182;
			hit_x = '0; hit_y = '0;
		endfunction

		function longint unsigned qsine(longint unsigned t);
			longint unsigned t2, inner, mid;
			t2 = (t * t) >> 16;
			inner = POLY_B - ((POLY_C * t2) >> 16);
			mid = POLY_A - ((t2 * inner) >> 16);
			return (t * mid) >> 16;
		endfunction

		// one axis position: offset from center truncated toward zero, plus the center
		function longint axis_pos(logic [15:0] r, logic [15:0] ph);
			logic [13:0]     frac;
			longint unsigned f, mag, num, den;
			longint          off;
			frac = ph[13:0];
			f = ph[14] ? (16384 - frac) : frac;
			mag = qsine(f << 2);
			num = longint'(r) * mag * IMG_DIM;
			den = longint'(r_high) * 2 * 65536;
			off = longint'(num / den);
			if (ph[15]) off = -off;
			return off + HALF;
		endfunction

		function void note(scan_item_t it);
			pix_result_t res;
			logic [31:0] ph32;
			logic [15:0] ph;
			longint      x, y;
			res = '{default: '0};
			if (it.action == ACT_READ) begin
				reads++;
				if (it.row < IMG_DIM && it.word < WPR) res.img = bmap[it.row * WPR + it.word];
			end else begin
				samples++;
				if (it.scan_start) begin
					clears++;
					foreach (bmap[i]) bmap[i] = '0;
				end
				if (it.beam < MAX_BEAMS && it.range_q > r_low && it.range_q < r_high) begin
					ph32 = {16'd0, a_start} + {20'd0, it.beam} * {16'd0, a_step};
					ph = ph32[15:0];
					x = axis_pos(it.range_q, ph + QUARTER_TURN);
					y = axis_pos(it.range_q, ph);
					if (x >= 0 && x < IMG_DIM && y >= 0 && y < IMG_DIM) begin
						bmap[y * WPR + (x >> 6)][x & 63] = 1'b1;
						res.px = 9'(x);
						res.py = 9'(y);
						res.set = 1'b1;
						hit_x = 9'(x);
						hit_y = 9'(y);
						pixels++;
					end
				end
			end
			awaited.insert(awaited.size(), res);
		endfunction

		function void check(pix_result_t got);
			pix_result_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing outstanding");
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.px !== want.px) begin
				$error("pixel_x expected %0d got %0d", want.px, got.px); errors++;
			end
			if (got.py !== want.py) begin
				$error("pixel_y expected %0d got %0d", want.py, got.py); errors++;
			end
			if (got.set !== want.set) begin
				$error("pixel_set expected %0d got %0d", want.set, got.set); errors++;
			end
			if (got.img !== want.img) begin
				$error("image_word expected %h got %h", want.img, got.img); errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;
	int snd_pct, rcv_pct;
	int beam_ctr;
	raster_board sb;

	s2b_in_if in_ch();
	s2b_out_if out_ch();

	scan_to_bitmap_rasterizer dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// receiver backpressure
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= rcv_pct);
	end

	// monitor both channels
	always @(posedge clk) begin
		scan_item_t  it;
		pix_result_t r;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			it.action = in_ch.action; it.range_q = in_ch.range_q; it.beam = in_ch.beam_index;
			it.scan_start = in_ch.scan_start; it.row = in_ch.read_row; it.word = in_ch.read_word;
			sb.note(it);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			r.px = out_ch.pixel_x; r.py = out_ch.pixel_y;
			r.set = out_ch.pixel_set; r.img = out_ch.image_word;
			sb.check(r);
		end
	end

	task automatic send_item(scan_item_t it);
		while (snd_pct > 0 && $urandom_range(99) < snd_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= it.action;
		in_ch.range_q <= it.range_q;
		in_ch.beam_index <= it.beam;
		in_ch.scan_start <= it.scan_start;
		in_ch.read_row <= it.row;
		in_ch.read_word <= it.word;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic sample(logic [15:0] r, logic [11:0] b, logic st);
		send_item('{ACT_SAMPLE, r, b, st, 9'd0, 3'd0});
	endtask

	task automatic read_word(logic [8:0] row, logic [2:0] w, logic st);
		send_item('{ACT_READ, 16'($urandom), 12'($urandom), st, row, w});
	endtask

	// let all outstanding results land, then allow the pipeline to settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic load_regs(logic [15:0] lo, logic [15:0] hi, logic [15:0] sa, logic [15:0] st);
		logic [15:0]          vals [4];
		logic [CFG_IDX_W-1:0] idx [4];
		vals = '{lo, hi, sa, st};
		idx = '{REG_RANGE_LOW, REG_RANGE_HIGH, REG_START_ANGLE, REG_ANGLE_STEP};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		sb.r_low = lo; sb.r_high = hi; sb.a_start = sa; sb.a_step = st;
	endtask

	// mostly well-formed scans, some reads, some noise
	task automatic random_burst(int count);
		int          k;
		logic [15:0] r;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(99);
			if (k < 70) begin
				if (beam_ctr >= 4096 || $urandom_range(79) == 0) beam_ctr = 0;
				if (sb.r_high > sb.r_low + 1 && $urandom_range(9) != 0)
					r = 16'($urandom_range(sb.r_high - 1, sb.r_low + 1));
				else
					r = 16'($urandom);
				sample(r, 12'(beam_ctr), beam_ctr == 0 && $urandom_range(3) == 0);
				beam_ctr += $urandom_range(1, 3);
			end else if (k < 78) begin
				read_word(sb.hit_y, 3'(sb.hit_x >> 6), 1'($urandom_range(1)));
			end else if (k < 85) begin
				read_word(9'($urandom), 3'($urandom), 1'($urandom_range(1)));
			end else begin
				sample(16'($urandom), 12'($urandom), $urandom_range(29) == 0);
			end
		end
	endtask

	// run limit
	initial begin
		#40ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [15:0] cfgs [8][4];
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
		in_ch.valid <= 1'b0; in_ch.action <= ACT_SAMPLE; in_ch.range_q <= '0;
		in_ch.beam_index <= '0; in_ch.scan_start <= 1'b0;
		in_ch.read_row <= '0; in_ch.read_word <= '0;
		snd_pct = 0; rcv_pct = 0; beam_ctr = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_regs(16'd0, 16'd65535, 16'd0, 16'd182);

		// directed: range edges, beam edges, clears, reads at image corners
		sample(16'd0, 12'd0, 1'b1);
		sample(16'd1, 12'd0, 1'b0);
		sample(16'd65535, 12'd10, 1'b0);
		sample(16'd65534, 12'd0, 1'b0);
		sample(16'd65534, 12'd90, 1'b0);
		sample(16'd65534, 12'd180, 1'b0);
		sample(16'd65534, 12'd270, 1'b0);
		sample(16'd32768, 12'd4095, 1'b0);
		sample(16'd40000, 12'd45, 1'b0);
		read_word(9'd256, 3'd7, 1'b0);
		read_word(9'd0, 3'd0, 1'b1);
		read_word(9'd511, 3'd7, 1'b0);
		read_word(sb.hit_y, 3'(sb.hit_x >> 6), 1'b0);
		sample(16'd20000, 12'd300, 1'b1);
		read_word(sb.hit_y, 3'(sb.hit_x >> 6), 1'b0);
		sample(16'hAAAA, 12'hAAA, 1'b0);
		sample(16'h5555, 12'h555, 1'b0);
		drain();

		cfgs = '{
			'{16'd0,     16'd65535, 16'd0,     16'd182},
			'{16'd0,     16'd65535, 16'h8000,  16'h8000},
			'{16'd65534, 16'd65535, 16'd100,   16'd7},
			'{16'd0,     16'd1,     16'h7FFF,  16'h7FFF},
			'{16'd256,   16'd2560,  16'd4096,  16'd91},
			'{16'd100,   16'd500,   16'hFC18,  16'hFF4A},
			'{16'd0,     16'd300,   16'd12345, 16'd1},
			'{16'd1000,  16'd40000, 16'hC000,  16'd737}
		};
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin snd_pct = 0;  rcv_pct = 0;  end
				1: begin snd_pct = 75; rcv_pct = 0;  end
				2: begin snd_pct = 0;  rcv_pct = 75; end
				default: begin snd_pct = 26; rcv_pct = 26; end
			endcase
			load_regs(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3]);
			beam_ctr = 0;
			random_burst(80);
			// sender holds off until everything is back, then resumes
			drain();
			random_burst(86);
			drain();
		end

		$display("covered %0d samples (%0d pixels set, %0d scan clears), %0d word reads",
			sb.samples, sb.pixels, sb.clears, sb.reads);
		$display("over 8 register settings with all four idle/stall mixes");
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* files.f */
rtl/s2b_pkg.sv
rtl/s2b_in_if.sv
rtl/s2b_out_if.sv
rtl/s2b_geom.sv
rtl/s2b_bitmap.sv
rtl/scan_to_bitmap_rasterizer.sv
rtl/s2b_checker.sv
sim/scan_to_bitmap_rasterizer_tb.sv
